// File: sv/calclk_pkg.sv
// ----------------------------------------------------------------------------
// calclk_pkg
// Types, codes and the month length rule of the calendar clock.
// ----------------------------------------------------------------------------
`default_nettype none

package calclk_pkg;

	localparam int unsigned DataBits = 40;
	localparam int unsigned OpBits   = 2;

	typedef enum logic [OpBits-1:0] {
		OP_TICK     = 2'd0,
		OP_SET_TIME = 2'd1,
		OP_SET_DATE = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
	} clock_t;

	typedef struct packed {
		clock_t clock;
		logic   new_day;
	} result_t;

	localparam logic [5:0] SecTop   = 6'd59;
	localparam logic [5:0] MinTop   = 6'd59;
	localparam logic [4:0] HourTop  = 5'd23;
	localparam logic [3:0] MonthTop = 4'd12;
	localparam logic [6:0] YearTop  = 7'd99;

	localparam logic [3:0] MonApr = 4'd4;
	localparam logic [3:0] MonJun = 4'd6;
	localparam logic [3:0] MonSep = 4'd9;
	localparam logic [3:0] MonNov = 4'd11;
	localparam logic [3:0] MonFeb = 4'd2;

	function automatic logic [4:0] month_length(input logic [3:0] month,
		input logic [6:0] year);
		logic [4:0] len;
		unique case (month)
			MonApr, MonJun, MonSep, MonNov: len = 5'd30;
			MonFeb: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// File: sv/calendar_clock_tick.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick
// Real-time calendar clock driven by tick, set-time and set-date transfers.
// ----------------------------------------------------------------------------
// Every input transfer yields one output transfer with the time and date after
// the operation, registered in the output or, on a stall, the skid register.
// One transfer is taken per cycle while the skid register is empty: the
// counters update in the cycle of acceptance, and a two-entry output buffer
// (output plus skid register) keeps the input open while a result waits.
`default_nettype none

module calendar_clock_tick (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// set_hour, set_minute, set_second, set_year, set_month, set_day, zero fill
	input  wire [calclk_pkg::DataBits-1:0] s_tdata,
	// operation
	input  wire [calclk_pkg::OpBits-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// hour, minute, second, year, month, day, zero fill
	output logic [calclk_pkg::DataBits-1:0] m_tdata,
	// new_day
	output logic                         m_tuser
);
	import calclk_pkg::*;

	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [4:0] day_q;
	logic [3:0] month_q;
	logic [6:0] year_q;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	clock_t  set_in;
	clock_t  next_clk;
	logic    next_new_day;
	result_t next_res;
	logic    accept;
	logic    out_free;
	op_t     op;

	assign set_in   = clock_t'(s_tdata[$bits(clock_t)-1:0]);
	assign op       = op_t'(s_tuser);
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		next_clk     = '{day: day_q, month: month_q, year: year_q,
			second: sec_q, minute: min_q, hour: hour_q};
		next_new_day = 1'b0;
		unique case (op)
			OP_TICK: begin
				if (sec_q < SecTop) begin
					next_clk.second = sec_q + 6'd1;
				end else begin
					next_clk.second = '0;
					if (min_q < MinTop) begin
						next_clk.minute = min_q + 6'd1;
					end else begin
						next_clk.minute = '0;
						if (hour_q < HourTop) begin
							next_clk.hour = hour_q + 5'd1;
						end else begin
							next_clk.hour = '0;
							next_new_day  = 1'b1;
							if (day_q < month_length(month_q, year_q)) begin
								next_clk.day = day_q + 5'd1;
							end else begin
								next_clk.day = 5'd1;
								if (month_q < MonthTop) begin
									next_clk.month = month_q + 4'd1;
								end else begin
									next_clk.month = 4'd1;
									next_clk.year  = (year_q < YearTop) ?
										year_q + 7'd1 : '0;
								end
							end
						end
					end
				end
			end
			OP_SET_TIME: begin
				next_clk.hour   = set_in.hour;
				next_clk.minute = set_in.minute;
				next_clk.second = set_in.second;
			end
			OP_SET_DATE: begin
				next_clk.year  = set_in.year;
				next_clk.month = set_in.month;
				next_clk.day   = set_in.day;
			end
			default: begin
			end
		endcase
		next_res = '{clock: next_clk, new_day: next_new_day};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			day_q   <= 5'd1;
			month_q <= 4'd1;
			year_q  <= '0;
		end else if (accept) begin
			sec_q   <= next_clk.second;
			min_q   <= next_clk.minute;
			hour_q  <= next_clk.hour;
			day_q   <= next_clk.day;
			month_q <= next_clk.month;
			year_q  <= next_clk.year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= next_res;
			end
		end else if (accept) begin
			skid_q <= next_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(DataBits-$bits(clock_t)){1'b0}}, out_q.clock};
	assign m_tuser  = out_q.new_day;

	a_new_day_midnight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> out_q.clock.hour == '0 && out_q.clock.minute == '0
			&& out_q.clock.second == '0)
		else $error("new day flagged away from midnight");

	a_skid_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register is empty");

	a_tick_second: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_TICK && sec_q < SecTop |=> sec_q == $past(sec_q) + 6'd1)
		else $error("tick did not advance the seconds");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted transfer produced no output");

endmodule

`default_nettype wire
